### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PJH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PJH_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PJH_ASSERT(label, clk, rst_n, prop, msg)
`define PJH_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### hw/rtl/pjh_pkg.sv
// ----------------------------------------------------------------------------
// pjh_pkg
// Shared types and constants of the period jitter histogram.
// ----------------------------------------------------------------------------
package pjh_pkg;

  localparam int TS_W    = 32;
  localparam int DEV_W   = 30;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 32;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 104;
  localparam int RND_ADD = 4;

  typedef enum logic [1:0] {
    OP_READ,
    OP_FIRST,
    OP_EVENT
  } pjh_op_t;

  typedef struct packed {
    pjh_op_t           op;
    logic [TS_W-1:0]   interval;
    logic [IDX_W-1:0]  idx;
  } pjh_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pjh_fifo_st_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } pjh_back_st_t;

  typedef struct packed {
    logic              jitter_valid;
    logic [DEV_W-1:0]  jitter;
    logic [IDX_W-1:0]  jitter_bin;
    logic [DEV_W-1:0]  max_jitter;
    logic [IDX_W-1:0]  max_bin;
    logic [CNT_W-1:0]  bin_count;
  } pjh_result_t;

endpackage

### hw/rtl/pjh_front.sv
// ----------------------------------------------------------------------------
// pjh_front
// Input side: accepts items, forms the interval and classifies each item.
// ----------------------------------------------------------------------------
module pjh_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_tuser,   // kind
  input  logic [pjh_pkg::IN_W-1:0]  in_tdata,   // timestamp, bin_index, pad
  input  pjh_pkg::pjh_fifo_st_t     fifo_st,
  input  pjh_pkg::pjh_back_st_t     bk_st,
  output logic                      push,
  output pjh_pkg::pjh_entry_t       entry
);
  import pjh_pkg::*;

  logic [TS_W-1:0]  prev_r, prev_nxt;
  logic             seen_r, seen_nxt;
  logic [TS_W-1:0]  stamp;

  assign stamp     = in_tdata[TS_W-1:0];
  assign in_tready = !fifo_st.full && !bk_st.clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    prev_nxt       = prev_r;
    seen_nxt       = seen_r;
    entry.interval = stamp - prev_r;
    entry.idx      = in_tdata[TS_W+IDX_W-1:TS_W];
    if (in_tuser) begin
      entry.op = OP_READ;
    end else begin
      entry.op = seen_r ? OP_EVENT : OP_FIRST;
      if (push) begin
        prev_nxt = stamp;
        seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      seen_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

### hw/rtl/pjh_fifo.sv
// ----------------------------------------------------------------------------
// pjh_fifo
// Two-entry queue between the input side and the histogram side.
// ----------------------------------------------------------------------------
module pjh_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pjh_pkg::pjh_entry_t   wr_entry,
  input  pjh_pkg::pjh_back_st_t bk_st,
  output pjh_pkg::pjh_entry_t   head,
  output pjh_pkg::pjh_fifo_st_t fifo_st
);
  import pjh_pkg::*;

  pjh_entry_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign head          = slot_r[rd_ptr_r];
  assign fifo_st.full  = cnt_r == 2'd2;
  assign fifo_st.empty = cnt_r == 2'd0;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = bk_st.pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !bk_st.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && bk_st.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/pjh_back.sv
// ----------------------------------------------------------------------------
// pjh_back
// Histogram side: deviation, clamping, maxima and bin read-modify-write.
// ----------------------------------------------------------------------------
module pjh_back #(
  parameter int BINS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pjh_pkg::TS_W-1:0]     cfg_data,
  input  pjh_pkg::pjh_entry_t          head,
  input  pjh_pkg::pjh_fifo_st_t        fifo_st,
  output pjh_pkg::pjh_back_st_t        bk_st,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output pjh_pkg::pjh_result_t         result
);
  import pjh_pkg::*;

  localparam int          BIN_W  = $clog2(BINS);
  localparam logic [31:0] BINS_U = 32'(BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

  logic [CNT_W-1:0]  hist_mem [BINS];
  logic [CNT_W-1:0]  rdata_r;

  logic [TS_W-1:0]   period_r;
  logic              clear_r, clear_nxt;
  logic [BIN_W-1:0]  clr_addr_r, clr_addr_nxt;

  logic              s1_vld_r, s1_vld_nxt;
  pjh_op_t           s1_op_r;
  logic [TS_W-1:0]   s1_abs_r;
  logic [IDX_W-1:0]  s1_idx_r;

  logic              s2_vld_r, s2_vld_nxt;
  pjh_op_t           s2_op_r;
  logic [DEV_W-1:0]  s2_dev_r;
  logic [BIN_W-1:0]  s2_bin_r;
  logic              s2_rd_ok_r;

  logic [DEV_W-1:0]  max_dev_r, max_dev_nxt;
  logic [BIN_W-1:0]  max_bin_r, max_bin_nxt;
  logic              out_vld_r, out_vld_nxt;
  pjh_result_t       out_r, out_nxt;

  logic              pop, s1_go, s2_go, out_free;
  logic [TS_W-1:0]   abs_w;
  logic [TS_W:0]     rnd_sum;
  logic [DEV_W-1:0]  dev_w;
  logic [BIN_W-1:0]  bin_w, idx_addr, raddr;
  logic              rd_ok_w;
  logic [BIN_W+IDX_W-1:0] idx_ext, bin_ext, max_ext;
  logic [CNT_W-1:0]  cnt_inc;
  logic              mem_we;
  logic [BIN_W-1:0]  waddr;
  logic [CNT_W-1:0]  wdata;

  assign out_free = !out_vld_r || out_tready;
  assign s2_go    = s2_vld_r && out_free;
  // read of the next bin only once the previous write has landed
  assign s1_go    = s1_vld_r && !s2_vld_r;
  assign pop      = !clear_r && !fifo_st.empty && (!s1_vld_r || s1_go);

  assign bk_st.clearing = clear_r;
  assign bk_st.pop      = pop;
  assign out_tvalid     = out_vld_r;
  assign result         = out_r;

  assign abs_w = (head.interval > period_r) ? head.interval - period_r
                                            : period_r - head.interval;

  assign rnd_sum  = {1'b0, s1_abs_r} + (TS_W+1)'(RND_ADD);
  assign dev_w    = rnd_sum[TS_W:3];
  assign bin_w    = ({2'b00, dev_w} >= BINS_U) ? LAST_BIN : BIN_W'(dev_w);
  assign idx_ext  = {{BIN_W{1'b0}}, s1_idx_r};
  assign idx_addr = idx_ext[BIN_W-1:0];
  assign rd_ok_w  = {{(32-IDX_W){1'b0}}, s1_idx_r} < BINS_U;
  assign raddr    = (s1_op_r == OP_READ) ? idx_addr : bin_w;

  assign cnt_inc = rdata_r + CNT_W'(1);
  assign bin_ext = {{IDX_W{1'b0}}, s2_bin_r};
  assign max_ext = {{IDX_W{1'b0}}, max_bin_nxt};

  assign mem_we = clear_r || (s2_go && s2_op_r == OP_EVENT);
  assign waddr  = clear_r ? clr_addr_r : s2_bin_r;
  assign wdata  = clear_r ? '0 : cnt_inc;

  always_comb begin
    clear_nxt    = clear_r;
    clr_addr_nxt = clr_addr_r;
    if (clear_r) begin
      clr_addr_nxt = clr_addr_r + BIN_W'(1);
      if (clr_addr_r == LAST_BIN) begin
        clear_nxt = 1'b0;
      end
    end
    s1_vld_nxt = pop || (s1_vld_r && !s1_go);
    s2_vld_nxt = s1_go || (s2_vld_r && !s2_go);
  end

  always_comb begin
    max_dev_nxt = max_dev_r;
    max_bin_nxt = max_bin_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_nxt     = out_r;
    if (s2_go) begin
      out_vld_nxt = 1'b1;
      out_nxt     = '0;
      case (s2_op_r)
        OP_EVENT: begin
          if (s2_dev_r > max_dev_r) begin
            max_dev_nxt = s2_dev_r;
          end
          if (s2_bin_r > max_bin_r) begin
            max_bin_nxt = s2_bin_r;
          end
          out_nxt.jitter_valid = 1'b1;
          out_nxt.jitter       = s2_dev_r;
          out_nxt.jitter_bin   = bin_ext[IDX_W-1:0];
          out_nxt.bin_count    = cnt_inc;
        end
        OP_READ: begin
          out_nxt.bin_count = s2_rd_ok_r ? rdata_r : '0;
        end
        default: begin
        end
      endcase
      out_nxt.max_jitter = max_dev_nxt;
      out_nxt.max_bin    = max_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[waddr] <= wdata;
    end
    if (s1_go) begin
      rdata_r <= hist_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r  <= head.op;
      s1_abs_r <= abs_w;
      s1_idx_r <= head.idx;
    end
    if (s1_go) begin
      s2_op_r    <= s1_op_r;
      s2_dev_r   <= dev_w;
      s2_bin_r   <= bin_w;
      s2_rd_ok_r <= rd_ok_w;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= '0;
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      max_dev_r  <= '0;
      max_bin_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_data;
      end
      clear_r    <= clear_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_vld_r   <= s1_vld_nxt;
      s2_vld_r   <= s2_vld_nxt;
      max_dev_r  <= max_dev_nxt;
      max_bin_r  <= max_bin_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

endmodule

### hw/rtl/period_jitter_histogram.sv
// ----------------------------------------------------------------------------
// period_jitter_histogram
// Jitter histogram of a periodic event stream.
// in_*: one item per transfer; tuser = kind (0 timestamp, 1 read bin).
//   A timestamp after the first one bins (|interval - period| + 4) / 8, clamped to BINS-1.
// out_*: exactly one result per input item, in order.
// cfg_*: writes expected_period; always ready, write only while idle.
// Each item passes the queue, stage 1, stage 2 and the output register.
// Items overlap in the pipeline, but the read-modify-write of the
//   histogram memory issues a read only after the prior write lands.
// Reset: maxima, previous timestamp and first-event flag clear; then a
//   clearing pass zeroes every histogram bin, in_tready low.
// A stalled out_tready holds the result; a two-entry queue keeps taking
//   input until full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module period_jitter_histogram #(
  parameter int BINS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,   // kind
  input  logic [pjh_pkg::IN_W-1:0]   in_tdata,   // timestamp[31:0], bin_index[37:32], zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic                       out_tuser,  // jitter_valid
  output logic [pjh_pkg::OUT_W-1:0]  out_tdata,  // jitter, jitter_bin, max_jitter, max_bin,
                                                 // bin_count
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pjh_pkg::TS_W-1:0]   cfg_data    // expected_period
);
  import pjh_pkg::*;

  pjh_entry_t    entry, head;
  pjh_fifo_st_t  fifo_st;
  pjh_back_st_t  bk_st;
  pjh_result_t   result;
  logic          push;

  assign cfg_ready = 1'b1;

  pjh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .fifo_st   (fifo_st),
    .bk_st     (bk_st),
    .push      (push),
    .entry     (entry)
  );

  pjh_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .bk_st    (bk_st),
    .head     (head),
    .fifo_st  (fifo_st)
  );

  pjh_back #(
    .BINS (BINS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .head       (head),
    .fifo_st    (fifo_st),
    .bk_st      (bk_st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  assign out_tuser = result.jitter_valid;
  assign out_tdata = {result.bin_count, result.max_bin, result.max_jitter,
                      result.jitter_bin, result.jitter};

  `PJH_NEVER(a_no_accept_clearing, clk, rst_n, in_tready && bk_st.clearing, "accept during clear")
  `PJH_NEVER(a_no_push_full, clk, rst_n, push && fifo_st.full, "push into full queue")
  `PJH_ASSERT(a_pop_nonempty, clk, rst_n, bk_st.pop |-> !fifo_st.empty, "pop from empty queue")

endmodule
